// ===== hw/rtl/adct_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ADC code to temperature package
// Shared widths, the code/temperature lookup table and the sequencer states.
// ----------------------------------------------------------------------------
package adct_pkg;

   // Entries held in the lookup table and the index width that addresses it.
   localparam int ROM_SIZE    = 34;
   localparam int ROM_IDX_W   = 6;

   // Width of the codes stored in the table and of the code comparison.
   localparam int ROM_CODE_W  = 12;
   localparam int CMP_W       = 16;

   // Temperature format and table spacing.
   localparam int TEMP_W      = 18;
   localparam int FIRST_MILLI = -40000;
   localparam int STEP_MILLI  = 5000;

   // Divider geometry. The numerator is at most 16 * 5000, the divisor
   // (code distance of one segment) at most 16, and the quotient is at
   // most the step size of 5000, reached when the code sits on an entry.
   localparam int NUM_W       = 17;
   localparam int DEN_W       = 5;
   localparam int QUO_W       = 13;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_START,
      ST_DIVIDE,
      ST_FINISH
   } adct_state_type;

   // Converter code of each table entry; codes fall as temperature rises.
   function automatic logic [ROM_CODE_W-1:0] rom_code(input logic [ROM_IDX_W-1:0] idx);
      logic [ROM_CODE_W-1:0] c;
      case (idx)
         6'd0:    c = 12'd3795;
         6'd1:    c = 12'd3787;
         6'd2:    c = 12'd3779;
         6'd3:    c = 12'd3769;
         6'd4:    c = 12'd3761;
         6'd5:    c = 12'd3751;
         6'd6:    c = 12'd3743;
         6'd7:    c = 12'd3733;
         6'd8:    c = 12'd3723;
         6'd9:    c = 12'd3713;
         6'd10:   c = 12'd3703;
         6'd11:   c = 12'd3693;
         6'd12:   c = 12'd3683;
         6'd13:   c = 12'd3673;
         6'd14:   c = 12'd3663;
         6'd15:   c = 12'd3651;
         6'd16:   c = 12'd3641;
         6'd17:   c = 12'd3629;
         6'd18:   c = 12'd3617;
         6'd19:   c = 12'd3605;
         6'd20:   c = 12'd3593;
         6'd21:   c = 12'd3581;
         6'd22:   c = 12'd3569;
         6'd23:   c = 12'd3555;
         6'd24:   c = 12'd3543;
         6'd25:   c = 12'd3529;
         6'd26:   c = 12'd3515;
         6'd27:   c = 12'd3501;
         6'd28:   c = 12'd3487;
         6'd29:   c = 12'd3471;
         6'd30:   c = 12'd3457;
         6'd31:   c = 12'd3441;
         6'd32:   c = 12'd3425;
         6'd33:   c = 12'd3409;
         default: c = 12'd0;
      endcase
      return c;
   endfunction

   // Temperature of each table entry in millidegrees Celsius.
   function automatic logic signed [TEMP_W-1:0] rom_milli(input logic [ROM_IDX_W-1:0] idx);
      return TEMP_W'(FIRST_MILLI + STEP_MILLI * int'(idx));
   endfunction

endpackage : adct_pkg
`default_nettype wire

// ===== hw/rtl/adct_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ADC code to temperature divider
// Restoring divider that retires one quotient bit per clock cycle.
// ----------------------------------------------------------------------------
module adct_divider (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [adct_pkg::NUM_W-1:0]   dividend,
   input  wire logic [adct_pkg::DEN_W-1:0]   divisor,
   output      logic                         done,
   output      logic [adct_pkg::QUO_W-1:0]   quotient
);
   import adct_pkg::*;

   localparam int CNT_W = $clog2(QUO_W + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [DEN_W-1:0]    rem_ff, rem_in;
   logic [DEN_W-1:0]    div_ff, div_in;
   logic [QUO_W-1:0]    quo_ff, quo_in;
   logic [DEN_W:0]      trial;
   logic                fits;

   // The partial remainder is always below the divisor, so the shifted
   // trial value needs only one more bit.
   assign trial = {rem_ff, quo_ff[QUO_W-1]};
   assign fits  = (trial >= {1'b0, div_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      if (start) begin
         // The quotient is known to fit in QUO_W bits, so the upper
         // dividend bits are already a valid partial remainder.
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = DEN_W'(dividend[NUM_W-1:QUO_W]);
         quo_in  = dividend[QUO_W-1:0];
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? DEN_W'(trial - {1'b0, div_ff}) : trial[DEN_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule : adct_divider
`default_nettype wire

// ===== hw/rtl/adc_code_to_temperature_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ADC code to temperature unit
// Converts a raw temperature-sensor code into millidegrees Celsius.
// ----------------------------------------------------------------------------
// One request transfer carries a converter code; one response transfer later
// returns the temperature in millidegrees Celsius as an 18-bit two's
// complement value. The code is located in a constant table of
// (code, temperature) pairs spaced 5000 millidegrees apart by a binary search
// that uses one shared comparator, one table probe per cycle. Codes at or
// above the first entry return -40000, codes below the last used entry return
// that entry's temperature, and anything in between is interpolated linearly
// with a quotient that truncates toward zero. The interpolation quotient comes
// from a restoring divider that produces one bit per cycle. A conversion runs
// from the request transfer until rsp_valid rises through the search, whose
// last step sees the bounds meet, the loading of the divider, the divider
// retiring its thirteen quotient bits and reporting done, and the loading of
// the response register once it is free; codes clamped at the table ends skip
// the divider. The unit works on one code at a time, so req_ready is low while
// a conversion is under way. The response sits in its own register, so a new
// request is taken while an earlier response still waits for rsp_ready.
// ----------------------------------------------------------------------------
module adc_code_to_temperature_unit #(
   parameter int TABLE_ENTRIES = 34,
   parameter int CODE_BITS     = 12
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire logic [CODE_BITS-1:0]                req_adc_code,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      logic signed [adct_pkg::TEMP_W-1:0]  rsp_temp_millicelsius
);
   import adct_pkg::*;

   // Number of table entries actually used and the width of a search bound,
   // which must also hold the "no entry matched" position.
   localparam int N     = (TABLE_ENTRIES < ROM_SIZE) ? TABLE_ENTRIES : ROM_SIZE;
   localparam int IDX_W = $clog2(N + 1);

   localparam logic signed [TEMP_W-1:0] FIRST_TEMP = rom_milli(ROM_IDX_W'(0));
   localparam logic signed [TEMP_W-1:0] LAST_TEMP  = rom_milli(ROM_IDX_W'(N - 1));

   adct_state_type              state_ff, state_in;
   logic [CODE_BITS-1:0]        code_ff, code_in;
   logic [IDX_W-1:0]            lo_ff, lo_in;
   logic [IDX_W-1:0]            hi_ff, hi_in;
   logic signed [TEMP_W-1:0]    result_ff, result_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [TEMP_W-1:0]    rsp_temp_ff, rsp_temp_in;

   logic [IDX_W-1:0]            mid;
   logic                        at_or_below;
   logic                        found;
   logic                        clamp_low;
   logic                        clamp_high;
   logic [ROM_IDX_W-1:0]        seg_lo;
   logic [ROM_IDX_W-1:0]        seg_hi;
   logic [CMP_W-1:0]            dist_hi;
   logic [CMP_W-1:0]            seg_span;
   logic [NUM_W-1:0]            numerator;
   logic                        div_start;
   logic                        div_done;
   logic [QUO_W-1:0]            quotient;
   logic                        out_free;
   logic                        accept;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // The search narrows [lo, hi] to the first entry whose code is at or
   // below the input; hi equal to N means no entry qualified. The midpoint
   // is formed from the distance between the bounds so it never overflows.
   assign mid         = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign at_or_below = CMP_W'(rom_code(ROM_IDX_W'(mid))) <= CMP_W'(code_ff);
   assign found       = (lo_ff == hi_ff);
   assign clamp_low   = (lo_ff == '0);
   assign clamp_high  = (lo_ff == IDX_W'(N));

   // Bracketing segment: seg_hi has the larger code, seg_lo the smaller.
   assign seg_lo   = ROM_IDX_W'(lo_ff);
   assign seg_hi   = ROM_IDX_W'(lo_ff - IDX_W'(1));
   assign dist_hi  = CMP_W'(rom_code(seg_hi)) - CMP_W'(code_ff);
   assign seg_span = CMP_W'(rom_code(seg_hi)) - CMP_W'(rom_code(seg_lo));

   // Temperature rises by one fixed step per segment, so the numerator is a
   // multiply by a constant of the small code distance.
   assign numerator = NUM_W'(dist_hi[DEN_W-1:0]) * NUM_W'(STEP_MILLI);

   adct_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (numerator),
      .divisor  (seg_span[DEN_W-1:0]),
      .done     (div_done),
      .quotient (quotient)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (found) begin
               state_in = (clamp_low || clamp_high) ? ST_FINISH : ST_START;
            end
         end
         ST_START: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control outputs.
   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_START: div_start = 1'b1;
         default: begin
            req_ready = 1'b0;
            div_start = 1'b0;
         end
      endcase
   end

   // Datapath registers.
   always_comb begin
      code_in      = code_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_temp_in  = rsp_temp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               code_in = req_adc_code;
               lo_in   = '0;
               hi_in   = IDX_W'(N);
            end
         end
         ST_SEARCH: begin
            if (found) begin
               if (clamp_low) begin
                  result_in = FIRST_TEMP;
               end else if (clamp_high) begin
                  result_in = LAST_TEMP;
               end
            end else if (at_or_below) begin
               hi_in = mid;
            end else begin
               lo_in = mid + IDX_W'(1);
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               result_in = rom_milli(seg_hi) + $signed({{(TEMP_W-QUO_W){1'b0}}, quotient});
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_temp_in  = result_ff;
            end
         end
         default: begin
            code_in = code_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      code_ff     <= code_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      result_ff   <= result_in;
      rsp_temp_ff <= rsp_temp_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_temp_millicelsius = rsp_temp_ff;

endmodule : adc_code_to_temperature_unit
`default_nettype wire
